### rtl/rfft_pkg.sv
`timescale 1ns / 1ps
package rfft_pkg;

   // fixed widths of the stream fields
   localparam int WORK_BITS     = 28;
   localparam int IDX_BITS      = 11;
   localparam int LOG2_BITS     = 4;
   localparam int RSP_DATA_BITS = 72;
   localparam int SAT_IN_BITS   = 34;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // defaults for the top level parameters
   localparam int DEF_MAX_POINTS   = 2048;
   localparam int DEF_SAMPLE_BITS  = 16;
   localparam int DEF_TWIDDLE_BITS = 16;

   localparam logic [LOG2_BITS-1:0] LOG2_RESET = 4'd11;

   // register index, taken from paddr bit 2
   localparam logic REG_LOG2_POINTS = 1'b0;
   localparam logic REG_REAL_INPUT  = 1'b1;

   // request kinds
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   localparam real PI_VAL = 3.14159265358979323846;

   // work memory write source
   typedef enum logic [1:0] {
      WR_SAMPLE,
      WR_SUM,
      WR_DIFF
   } wr_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       real_mode;
      logic       mul_en;
      logic       sum_en;
      logic       out_load;
      logic       out_ok;
      logic       out_last;
   } rfft_cmd_type;

   // round to nearest, ties away from zero
   function automatic real round_away(input real v);
      real r;
      if (v >= 0.0) begin
         r = $floor(v + 0.5);
      end else begin
         r = -$floor(-v + 0.5);
      end
      return r;
   endfunction

   // cosine twiddle, saturated at full scale minus one
   // step is the angle between neighboring table entries
   function automatic logic signed [31:0] tw_cos(input int k, input real step, input int twb);
      real scale;
      real r;
      scale = 2.0 ** (twb - 1);
      r = round_away($cos(step * k) * scale);
      if (r > scale - 1.0) begin
         r = scale - 1.0;
      end
      return 32'($rtoi(r));
   endfunction

   // negated sine twiddle
   function automatic logic signed [31:0] tw_sin(input int k, input real step, input int twb);
      real scale;
      real r;
      scale = 2.0 ** (twb - 1);
      r = round_away($sin(step * k) * scale);
      return -32'($rtoi(r));
   endfunction

   // saturate to the work word
   function automatic logic signed [WORK_BITS-1:0] sat_work(
      input logic signed [SAT_IN_BITS-1:0] v);
      logic signed [SAT_IN_BITS-1:0] hi;
      logic signed [SAT_IN_BITS-1:0] lo;
      hi = SAT_IN_BITS'(signed'({1'b0, {(WORK_BITS-1){1'b1}}}));
      lo = -hi - SAT_IN_BITS'(1);
      if (v > hi) begin
         return hi[WORK_BITS-1:0];
      end else if (v < lo) begin
         return lo[WORK_BITS-1:0];
      end
      return v[WORK_BITS-1:0];
   endfunction

endpackage

### rtl/rfft_dp.sv
`timescale 1ns / 1ps
module rfft_dp
   import rfft_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rfft_cmd_type                  cmd,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_addr_a,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_addr_b,
   input  logic [((MAX_POINTS > 2) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] tw_addr,
   input  logic [$clog2(MAX_POINTS)-1:0] out_idx,
   input  logic signed [SAMPLE_BITS-1:0] sample_re,
   input  logic signed [SAMPLE_BITS-1:0] sample_im,
   output logic [RSP_DATA_BITS-1:0]      rsp_data,
   output logic                          rsp_last,
   output logic                          rsp_ok
);

   localparam int  TW_DEPTH = MAX_POINTS / 2;
   localparam real TW_STEP  = 2.0 * PI_VAL / MAX_POINTS;
   localparam int  PW       = WORK_BITS + TWIDDLE_BITS;
   localparam int  TB       = WORK_BITS + 2;

   logic signed [WORK_BITS-1:0] mem_re [MAX_POINTS];
   logic signed [WORK_BITS-1:0] mem_im [MAX_POINTS];

   logic signed [TWIDDLE_BITS-1:0] tw_re_rom [TW_DEPTH];
   logic signed [TWIDDLE_BITS-1:0] tw_im_rom [TW_DEPTH];

   logic signed [WORK_BITS-1:0]    ra_re_ff, ra_im_ff, rb_re_ff, rb_im_ff;
   logic signed [TWIDDLE_BITS-1:0] twr_ff, twi_ff;
   logic signed [PW-1:0]           prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [WORK_BITS-1:0]    sum_re_ff, sum_im_ff, dif_re_ff, dif_im_ff;
   logic signed [PW:0]             acc_re, acc_im;
   logic signed [TB-1:0]           t_re, t_im;
   logic signed [WORK_BITS-1:0]    wd_re, wd_im;
   logic signed [WORK_BITS-1:0]    smp_re, smp_im;

   logic signed [WORK_BITS-1:0] bin_re_ff, bin_im_ff;
   logic [IDX_BITS-1:0]         bin_idx_ff;
   logic                        last_ff, ok_ff;

   // twiddle constants
   for (genvar g = 0; g < TW_DEPTH; g++) begin : g_tw
      assign tw_re_rom[g] = TWIDDLE_BITS'(tw_cos(g, TW_STEP, TWIDDLE_BITS));
      assign tw_im_rom[g] = TWIDDLE_BITS'(tw_sin(g, TW_STEP, TWIDDLE_BITS));
   end

   // loaded sample, widened and saturated
   assign smp_re = sat_work(SAT_IN_BITS'(sample_re));
   assign smp_im = cmd.real_mode ? '0 : sat_work(SAT_IN_BITS'(sample_im));

   // write data select
   always_comb begin
      case (cmd.wr_sel)
         WR_SAMPLE: begin
            wd_re = smp_re;
            wd_im = smp_im;
         end
         WR_SUM: begin
            wd_re = sum_re_ff;
            wd_im = sum_im_ff;
         end
         WR_DIFF: begin
            wd_re = dif_re_ff;
            wd_im = dif_im_ff;
         end
         default: begin
            wd_re = smp_re;
            wd_im = smp_im;
         end
      endcase
   end

   // work memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_re[wr_addr] <= wd_re;
         mem_im[wr_addr] <= wd_im;
      end
      ra_re_ff <= mem_re[rd_addr_a];
      ra_im_ff <= mem_im[rd_addr_a];
      rb_re_ff <= mem_re[rd_addr_b];
      rb_im_ff <= mem_im[rd_addr_b];
      twr_ff   <= tw_re_rom[tw_addr];
      twi_ff   <= tw_im_rom[tw_addr];
   end

   // twiddle products
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prr_ff <= twr_ff * rb_re_ff;
         pii_ff <= twi_ff * rb_im_ff;
         pri_ff <= twi_ff * rb_re_ff;
         pir_ff <= twr_ff * rb_im_ff;
      end
   end

   // round products, shift down with floor
   assign acc_re = (PW+1)'(prr_ff) - (PW+1)'(pii_ff)
                 + (PW+1)'(signed'({1'b0, 1'b1, {(TWIDDLE_BITS-2){1'b0}}}));
   assign acc_im = (PW+1)'(pri_ff) + (PW+1)'(pir_ff)
                 + (PW+1)'(signed'({1'b0, 1'b1, {(TWIDDLE_BITS-2){1'b0}}}));
   assign t_re   = TB'(acc_re >>> (TWIDDLE_BITS - 1));
   assign t_im   = TB'(acc_im >>> (TWIDDLE_BITS - 1));

   // butterfly sum and difference
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_re_ff <= sat_work(SAT_IN_BITS'(ra_re_ff) + SAT_IN_BITS'(t_re));
         sum_im_ff <= sat_work(SAT_IN_BITS'(ra_im_ff) + SAT_IN_BITS'(t_im));
         dif_re_ff <= sat_work(SAT_IN_BITS'(ra_re_ff) - SAT_IN_BITS'(t_re));
         dif_im_ff <= sat_work(SAT_IN_BITS'(ra_im_ff) - SAT_IN_BITS'(t_im));
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_re_ff  <= '0;
         bin_im_ff  <= '0;
         bin_idx_ff <= '0;
         last_ff    <= 1'b0;
         ok_ff      <= 1'b0;
      end else if (cmd.out_load) begin
         bin_re_ff  <= cmd.out_ok ? ra_re_ff : '0;
         bin_im_ff  <= cmd.out_ok ? ra_im_ff : '0;
         bin_idx_ff <= cmd.out_ok ? IDX_BITS'(out_idx) : '0;
         last_ff    <= cmd.out_ok & cmd.out_last;
         ok_ff      <= cmd.out_ok;
      end
   end

   assign rsp_data = {{(RSP_DATA_BITS - 2*WORK_BITS - IDX_BITS){1'b0}},
                      bin_idx_ff, bin_im_ff, bin_re_ff};
   assign rsp_last = last_ff;
   assign rsp_ok   = ok_ff;

endmodule

### rtl/rfft_ctrl.sv
`timescale 1ns / 1ps
module rfft_ctrl
   import rfft_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_opcode,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output rfft_cmd_type                  cmd,
   output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   output logic [$clog2(MAX_POINTS)-1:0] rd_addr_a,
   output logic [$clog2(MAX_POINTS)-1:0] rd_addr_b,
   output logic [((MAX_POINTS > 2) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] tw_addr,
   output logic [$clog2(MAX_POINTS)-1:0] out_idx
);

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int LOGMAX = AW;
   localparam int CW  = AW + 1;
   localparam int TIW = (MAX_POINTS > 2) ? AW - 1 : 1;
   localparam int JW  = (AW > 1) ? AW - 1 : 1;
   localparam int BW  = $clog2(LOGMAX + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FETCH = 7'b0000010,
      S_RD    = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_SUM   = 7'b0010000,
      S_WP    = 7'b0100000,
      S_WQ    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [LOG2_BITS-1:0] log2_ff;
   logic                 real_ff;
   logic [CW-1:0]        load_cnt_ff, load_cnt_in;
   logic [AW-1:0]        read_cnt_ff, read_cnt_in;
   logic                 done_ff, done_in;
   logic [BW-1:0]        fbits_ff, fbits_in;
   logic [BW-1:0]        stage_ff, stage_in;
   logic [JW-1:0]        bfly_ff, bfly_in;
   logic [AW-1:0]        fidx_ff, fidx_in;
   logic                 flast_ff, flast_in;
   logic                 fok_ff, fok_in;
   logic                 rvalid_ff, rvalid_in;

   logic          csr_wr, accept, push, fetch;
   logic [BW-1:0] cur_bits;
   logic [AW-1:0] cur_mask, fmask, pos, rev, push_addr;
   logic [CW-1:0] eff_load, load_next, cur_n;
   logic          push_last;
   logic [AW-1:0] jx, lmask, p_addr, q_addr, s_off, idx;
   logic [JW-1:0] jmask;
   logic          j_last, st_last, idx_last;

   // configuration registers
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= LOG2_RESET;
         real_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_LOG2_POINTS: log2_ff <= csr_pwdata[LOG2_BITS-1:0];
            REG_REAL_INPUT:  real_ff <= csr_pwdata[0];
            default:         log2_ff <= log2_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_LOG2_POINTS: csr_prdata = CSR_DATA_BITS'(log2_ff);
         REG_REAL_INPUT:  csr_prdata = CSR_DATA_BITS'(real_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // transform length in use, clamped
   always_comb begin
      if (log2_ff == '0) begin
         cur_bits = BW'(1);
      end else if (int'(log2_ff) > LOGMAX) begin
         cur_bits = BW'(LOGMAX);
      end else begin
         cur_bits = BW'(log2_ff);
      end
   end

   assign cur_mask = ~({AW{1'b1}} << cur_bits);
   assign cur_n    = CW'(1) << cur_bits;
   assign fmask    = ~({AW{1'b1}} << fbits_ff);

   // push address, bit reversed within the current length
   assign eff_load  = done_ff ? '0 : load_cnt_ff;
   assign pos       = eff_load[AW-1:0] & cur_mask;
   always_comb begin
      for (int i = 0; i < AW; i++) begin
         rev[i] = pos[AW-1-i];
      end
   end
   assign push_addr = rev >> (BW'(LOGMAX) - cur_bits);
   assign load_next = eff_load + CW'(1);
   assign push_last = load_next >= cur_n;

   // butterfly addressing
   assign jx     = AW'(bfly_ff);
   assign lmask  = ~({AW{1'b1}} << stage_ff);
   assign p_addr = ((jx & ~lmask) << 1) | (jx & lmask);
   assign q_addr = p_addr | (AW'(1) << stage_ff);
   assign s_off  = jx & lmask;
   assign jmask  = ~({JW{1'b1}} << (fbits_ff - BW'(1)));
   assign j_last = bfly_ff == jmask;
   assign st_last = stage_ff == (fbits_ff - BW'(1));

   // fetch index
   assign idx      = read_cnt_ff & fmask;
   assign idx_last = idx == fmask;

   // request handshake
   assign req_tready = (state_ff == S_IDLE) & (~rvalid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;
   assign push       = accept & (req_opcode == OP_PUSH);
   assign fetch      = accept & (req_opcode == OP_FETCH);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      read_cnt_in = read_cnt_ff;
      done_in     = done_ff;
      fbits_in    = fbits_ff;
      stage_in    = stage_ff;
      bfly_in     = bfly_ff;
      fidx_in     = fidx_ff;
      flast_in    = flast_ff;
      fok_in      = fok_ff;
      rvalid_in   = rvalid_ff & ~rsp_tready;
      cmd         = '0;
      cmd.wr_sel  = WR_SAMPLE;
      cmd.real_mode = real_ff;
      cmd.out_ok  = fok_ff;
      cmd.out_last = flast_ff;
      wr_addr     = push_addr;
      rd_addr_a   = p_addr;
      case (state_ff)
         S_IDLE: begin
            rd_addr_a = idx;
            if (push) begin
               cmd.wr_en = 1'b1;
               done_in   = 1'b0;
               if (push_last) begin
                  load_cnt_in = '0;
                  read_cnt_in = '0;
                  fbits_in    = cur_bits;
                  stage_in    = '0;
                  bfly_in     = '0;
                  state_in    = S_RD;
               end else begin
                  load_cnt_in = load_next;
                  if (done_ff) begin
                     read_cnt_in = '0;
                  end
               end
            end else if (fetch) begin
               fok_in   = done_ff;
               fidx_in  = idx;
               flast_in = idx_last;
               state_in = S_FETCH;
               if (done_ff) begin
                  if (idx_last) begin
                     done_in     = 1'b0;
                     read_cnt_in = '0;
                     load_cnt_in = '0;
                  end else begin
                     read_cnt_in = idx + AW'(1);
                  end
               end
            end
         end
         S_FETCH: begin
            cmd.out_load = 1'b1;
            rvalid_in    = 1'b1;
            state_in     = S_IDLE;
         end
         S_RD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_WP;
         end
         S_WP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SUM;
            wr_addr    = p_addr;
            state_in   = S_WQ;
         end
         S_WQ: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_DIFF;
            wr_addr    = q_addr;
            state_in   = S_RD;
            if (j_last) begin
               bfly_in = '0;
               if (st_last) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  stage_in = stage_ff + BW'(1);
               end
            end else begin
               bfly_in = bfly_ff + JW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_addr_b  = q_addr;
   assign tw_addr    = TIW'(s_off << (BW'(LOGMAX - 1) - stage_ff));
   assign out_idx    = fidx_ff;
   assign rsp_tvalid = rvalid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         load_cnt_ff <= '0;
         read_cnt_ff <= '0;
         done_ff     <= 1'b0;
         fbits_ff    <= BW'(1);
         stage_ff    <= '0;
         bfly_ff     <= '0;
         fok_ff      <= 1'b0;
         flast_ff    <= 1'b0;
         rvalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         read_cnt_ff <= read_cnt_in;
         done_ff     <= done_in;
         fbits_ff    <= fbits_in;
         stage_ff    <= stage_in;
         bfly_ff     <= bfly_in;
         fok_ff      <= fok_in;
         flast_ff    <= flast_in;
         rvalid_ff   <= rvalid_in;
      end
   end

   // fetch index needs no reset
   always_ff @(posedge clock) begin
      fidx_ff <= fidx_in;
   end

endmodule

### rtl/radix2_fft_core.sv
`timescale 1ns / 1ps
// Radix-2 decimation-in-time FFT over N = 2^log2_points complex points.
// Requests come in on req_*: tuser is the kind (0 push a sample, 1 fetch a
// bin), tdata carries sample_re and sample_im. A push stores the sample at
// its bit-reversed address. The Nth push starts the transform: butterflies
// run one at a time through the states read, multiply, sum, write p, write
// q, on the shared complex multiplier and single work memory; req_tready
// stays low until it is done. A fetch goes from idle through S_FETCH, which
// loads the result register and raises rsp_tvalid; no request is taken in
// S_FETCH. Bins come in natural order; tlast marks the final bin, tuser = 0
// means no finished transform was available (all fields zero). If
// rsp_tready is low, the held result stays and no new request is taken
// until it leaves. Registers: log2_points at 0x0, real_input at 0x4, to be
// written by the user over csr_* while the block is idle; the block itself
// does not enforce it. Reset clears counters and flags and sets log2_points
// to 11; the work memory holds no data until a frame is loaded.
module radix2_fft_core
   import rfft_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                         csr_pready,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // sample_re, sample_im
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // opcode
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // bin_re, bin_im, bin_index
   output logic [RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                         rsp_tlast,
   // ready_res
   output logic                         rsp_tuser
);

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int TIW = (MAX_POINTS > 2) ? AW - 1 : 1;

   rfft_cmd_type  cmd;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b, out_idx;
   logic [TIW-1:0] tw_addr;

   // sequencer and configuration
   rfft_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_opcode  (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .wr_addr     (wr_addr),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .tw_addr     (tw_addr),
      .out_idx     (out_idx)
   );

   // memory, twiddles and butterfly arithmetic
   rfft_dp #(
      .MAX_POINTS   (MAX_POINTS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .TWIDDLE_BITS (TWIDDLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .tw_addr   (tw_addr),
      .out_idx   (out_idx),
      .sample_re (signed'(req_tdata[SAMPLE_BITS-1:0])),
      .sample_im (signed'(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast),
      .rsp_ok    (rsp_tuser)
   );

endmodule
